// ===== src/folb_pkg.sv =====
package folb_pkg;

  // fixed widths of the transaction fields
  localparam int OpW        = 3;
  localparam int ChanW      = 4;
  localparam int SampleBits = 16;

  // fixed point: state and coefficients in Q(FracBits)
  localparam int FracBits   = 16;
  localparam int CoefQ      = 24;
  localparam int CoefShift  = CoefQ - FracBits;
  localparam int CoefRound  = (CoefShift == 0) ? 0 : (1 << (CoefShift - 1));
  localparam int CoefW      = FracBits + 2;
  localparam int StateW     = SampleBits + FracBits + 2;
  localparam int ProdW      = StateW + CoefW;
  localparam int RoundW     = StateW + 1 - FracBits;

  localparam int NumCutoffs  = 5;
  localparam int DefChannels = 16;

  // result queue size, also the number of transactions that may be in flight
  localparam int FifoDepth = 8;

  typedef enum logic [OpW-1:0] {
    Cut8Hz    = 3'd0,
    Cut4Hz    = 3'd1,
    Cut2Hz    = 3'd2,
    Cut1Hz    = 3'd3,
    CutHalfHz = 3'd4
  } cutoff_e;

  // bilinear first-order design, Q24
  localparam logic [CoefQ-1:0] PoleQ24 [NumCutoffs] = '{
    CoefQ'(4874232), CoefQ'(9922018), CoefQ'(13013743), CoefQ'(14791106), CoefQ'(15754854)
  };
  localparam logic [CoefQ-1:0] InvGainQ24 [NumCutoffs] = '{
    CoefQ'(5951492), CoefQ'(3427599), CoefQ'(1881737), CoefQ'(993055), CoefQ'(511181)
  };

  // Q24 to Q(FracBits), rounding half up
  function automatic logic signed [CoefW-1:0] to_frac(logic [CoefQ-1:0] k);
    logic [CoefQ:0] t;
    t = {1'b0, k} + (CoefQ+1)'(CoefRound);
    return CoefW'(t >> CoefShift);
  endfunction

  function automatic logic signed [CoefW-1:0] pole_frac(logic [OpW-1:0] sel);
    logic signed [CoefW-1:0] c;
    unique case (cutoff_e'(sel))
      Cut8Hz:    c = to_frac(PoleQ24[0]);
      Cut4Hz:    c = to_frac(PoleQ24[1]);
      Cut2Hz:    c = to_frac(PoleQ24[2]);
      Cut1Hz:    c = to_frac(PoleQ24[3]);
      CutHalfHz: c = to_frac(PoleQ24[4]);
      default:   c = '0;
    endcase
    return c;
  endfunction

  function automatic logic signed [CoefW-1:0] gain_frac(logic [OpW-1:0] sel);
    logic signed [CoefW-1:0] c;
    unique case (cutoff_e'(sel))
      Cut8Hz:    c = to_frac(InvGainQ24[0]);
      Cut4Hz:    c = to_frac(InvGainQ24[1]);
      Cut2Hz:    c = to_frac(InvGainQ24[2]);
      Cut1Hz:    c = to_frac(InvGainQ24[3]);
      CutHalfHz: c = to_frac(InvGainQ24[4]);
      default:   c = '0;
    endcase
    return c;
  endfunction

endpackage

// ===== src/first_order_lowpass_bank.sv =====
// Bank of first-order low-pass filters (50 Hz sample rate, cutoffs of about 8, 4, 2, 1 and
// 0.5 Hz), one filter state per cutoff and channel, held in a single-port-write,
// registered-read state RAM of 5*CHANNELS words. The block takes one transaction per cycle
// while in_ready_o is high and passes it through the s1, s2 and s3 pipeline registers into the
// output queue (RAM read at acceptance, then multiply, accumulate and write back, round and
// saturate). The output queue has 8 entries and out_valid_o is high while it holds a result;
// up to eight transactions may be in flight, and in_ready_o drops when that queue would
// overflow and while the state RAM is being cleared.
// Back-to-back transactions on the same filter are served by forwarding the state still in
// the pipeline. After reset the state RAM is cleared one word a cycle, which keeps
// in_ready_o low until every word is cleared. An unused cutoff select or a channel at or above
// CHANNELS gives a filtered value of zero and leaves every state untouched.
module first_order_lowpass_bank #(
  parameter int CHANNELS = folb_pkg::DefChannels
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [folb_pkg::OpW-1:0]               operation_i,
  input  logic [folb_pkg::ChanW-1:0]             channel_i,
  input  logic signed [folb_pkg::SampleBits-1:0] sample_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [folb_pkg::SampleBits-1:0] filtered_o
);

  localparam int Depth  = folb_pkg::NumCutoffs * CHANNELS;
  localparam int AddrW  = $clog2(Depth);
  localparam int StateW = folb_pkg::StateW;
  localparam int CoefW  = folb_pkg::CoefW;
  localparam int ProdW  = folb_pkg::ProdW;
  localparam int FracB  = folb_pkg::FracBits;
  localparam int SampW  = folb_pkg::SampleBits;
  localparam int RndW   = folb_pkg::RoundW;
  localparam int FifoAw = $clog2(folb_pkg::FifoDepth);
  localparam int CntW   = $clog2(folb_pkg::FifoDepth + 1);

  localparam logic signed [ProdW-1:0]  ProdHalf = ProdW'(longint'(1) << (FracB - 1));
  localparam logic signed [StateW:0]   YHalf    = (StateW+1)'(longint'(1) << (FracB - 1));
  localparam logic signed [RndW-1:0]   OutMax   = RndW'((longint'(1) << (SampW - 1)) - 1);
  localparam logic signed [RndW-1:0]   OutMin   = RndW'(-(longint'(1) << (SampW - 1)));

  // state ram: {prev scaled input, prev output}
  logic [2*StateW-1:0] mem_q [Depth];
  logic [2*StateW-1:0] rd_q;
  logic                mem_we;
  logic [AddrW-1:0]    mem_wa;
  logic [2*StateW-1:0] mem_wd;

  logic             clr_busy_q;
  logic [AddrW-1:0] clr_addr_q;

  logic             in_acc;
  logic             in_good;
  logic [AddrW-1:0] in_addr;

  logic                    s1_v_q, s1_good_q;
  logic [AddrW-1:0]        s1_addr_q;
  logic [folb_pkg::OpW-1:0] s1_op_q;
  logic signed [SampW-1:0] s1_sample_q;

  logic                     s2_v_q, s2_good_q;
  logic [AddrW-1:0]         s2_addr_q;
  logic signed [StateW-1:0] s2_xs_q, s2_xs_prev_q;
  logic signed [ProdW-1:0]  s2_prod_q;

  logic                     s3_v_q, s3_good_q;
  logic [AddrW-1:0]         s3_addr_q;
  logic signed [StateW-1:0] s3_xs_q, s3_y_q;

  logic [SampW-1:0]  fifo_q [folb_pkg::FifoDepth];
  logic [FifoAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   fifo_cnt_q, credit_q;
  logic              out_acc;

  // input side: accept while credits remain and the state ram is cleared
  assign in_ready_o = !clr_busy_q && (credit_q < CntW'(folb_pkg::FifoDepth));
  assign in_acc     = in_valid_i && in_ready_o;
  assign in_good    = (operation_i < folb_pkg::OpW'(folb_pkg::NumCutoffs)) &&
                      (int'(channel_i) < CHANNELS);
  assign in_addr    = AddrW'(AddrW'(operation_i) * AddrW'(CHANNELS) + AddrW'(channel_i));

  // clearing pass after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      if (clr_addr_q == AddrW'(Depth - 1)) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end
    end
  end

  // stage 1: state from ram or forwarded from the younger write-backs
  logic signed [StateW-1:0] s1_xs_prev, s1_y_prev;
  logic signed [StateW-1:0] s2_y;
  logic signed [CoefW-1:0]  s1_pole, s1_gain;

  always_comb begin
    if (s2_v_q && s2_good_q && (s2_addr_q == s1_addr_q)) begin
      s1_xs_prev = s2_xs_q;
      s1_y_prev  = s2_y;
    end else if (s3_v_q && s3_good_q && (s3_addr_q == s1_addr_q)) begin
      s1_xs_prev = s3_xs_q;
      s1_y_prev  = s3_y_q;
    end else begin
      s1_xs_prev = signed'(rd_q[2*StateW-1:StateW]);
      s1_y_prev  = signed'(rd_q[StateW-1:0]);
    end
  end

  assign s1_pole = folb_pkg::pole_frac(s1_op_q);
  assign s1_gain = folb_pkg::gain_frac(s1_op_q);

  // stage 2: accumulate and write back
  logic signed [ProdW-1:0]  s2_prod_rnd;
  logic signed [StateW-1:0] s2_py;

  assign s2_prod_rnd = s2_prod_q + ProdHalf;
  assign s2_py       = signed'(s2_prod_rnd[FracB +: StateW]);
  assign s2_y        = s2_xs_prev_q + s2_xs_q + s2_py;

  assign mem_we = clr_busy_q || (s2_v_q && s2_good_q);
  assign mem_wa = clr_busy_q ? clr_addr_q : s2_addr_q;
  assign mem_wd = clr_busy_q ? '0 : {s2_xs_q, s2_y};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (in_acc) begin
      rd_q <= mem_q[in_addr];
    end
  end

  // pipeline valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      s1_v_q <= in_acc;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    s1_good_q    <= in_good;
    s1_addr_q    <= in_addr;
    s1_op_q      <= operation_i;
    s1_sample_q  <= sample_i;
    s2_good_q    <= s1_good_q;
    s2_addr_q    <= s1_addr_q;
    s2_xs_prev_q <= s1_xs_prev;
    s2_xs_q      <= StateW'(StateW'(s1_sample_q) * StateW'(s1_gain));
    s2_prod_q    <= ProdW'(s1_y_prev) * ProdW'(s1_pole);
    s3_good_q    <= s2_good_q;
    s3_addr_q    <= s2_addr_q;
    s3_xs_q      <= s2_xs_q;
    s3_y_q       <= s2_y;
  end

  // stage 3: round and saturate, zero for an unused select or channel
  logic signed [StateW:0]   s3_y_rnd;
  logic signed [RndW-1:0]   s3_o;
  logic signed [SampW-1:0]  s3_out;

  assign s3_y_rnd = {s3_y_q[StateW-1], s3_y_q} + YHalf;
  assign s3_o     = signed'(s3_y_rnd[StateW:FracB]);

  always_comb begin
    priority if (!s3_good_q) begin
      s3_out = '0;
    end else if (s3_o > OutMax) begin
      s3_out = OutMax[SampW-1:0];
    end else if (s3_o < OutMin) begin
      s3_out = OutMin[SampW-1:0];
    end else begin
      s3_out = s3_o[SampW-1:0];
    end
  end

  // result queue and credit count
  assign out_valid_o = (fifo_cnt_q != '0);
  assign out_acc     = out_valid_o && out_ready_i;
  assign filtered_o  = signed'(fifo_q[rd_ptr_q]);

  always_ff @(posedge clk_i) begin
    if (s3_v_q) begin
      fifo_q[wr_ptr_q] <= s3_out;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
      credit_q   <= '0;
    end else begin
      if (s3_v_q) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (out_acc) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      fifo_cnt_q <= fifo_cnt_q + CntW'(s3_v_q) - CntW'(out_acc);
      credit_q   <= credit_q + CntW'(in_acc) - CntW'(out_acc);
    end
  end

endmodule

// ===== tb/sv/first_order_lowpass_bank_tb.sv =====
`timescale 1ns / 100ps

module first_order_lowpass_bank_tb;

  // one filter transaction as offered on the input channel
  typedef struct {
    logic [folb_pkg::OpW-1:0]               op;
    logic [folb_pkg::ChanW-1:0]             ch;
    logic signed [folb_pkg::SampleBits-1:0] smp;
  } lp_item_t;

  // Q24 design coefficients, brought down to the working fraction width
  localparam longint LpPoleQ24    [folb_pkg::NumCutoffs] = '{
    4874232, 9922018, 13013743, 14791106, 15754854
  };
  localparam longint LpInvGainQ24 [folb_pkg::NumCutoffs] = '{
    5951492, 3427599, 1881737, 993055, 511181
  };
  localparam int     CoefDrop  = 24 - folb_pkg::FracBits;
  localparam int     NumOps    = 1 << folb_pkg::OpW;
  localparam int     NumChans  = 1 << folb_pkg::ChanW;
  localparam int     HoldLen   = 120;
  localparam longint SampleMax = (longint'(1) <<< (folb_pkg::SampleBits - 1)) - 1;
  localparam longint SampleMin = -(longint'(1) <<< (folb_pkg::SampleBits - 1));
  localparam int     SmpMaxInt = int'(SampleMax);
  localparam int     SmpMinInt = int'(SampleMin);

  logic                                   clk_i       = 1'b0;
  logic                                   rst_ni      = 1'b0;
  logic                                   in_valid_i  = 1'b0;
  logic                                   in_ready_o;
  logic [folb_pkg::OpW-1:0]               operation_i = '0;
  logic [folb_pkg::ChanW-1:0]             channel_i   = '0;
  logic signed [folb_pkg::SampleBits-1:0] sample_i    = '0;
  logic                                   out_valid_o;
  logic                                   out_ready_i = 1'b0;
  logic signed [folb_pkg::SampleBits-1:0] filtered_o;

  // per-filter history held by the predictor
  longint scaled_in_hist [folb_pkg::NumCutoffs][folb_pkg::DefChannels];
  longint output_hist    [folb_pkg::NumCutoffs][folb_pkg::DefChannels];

  lp_item_t                               sample_q[$];
  logic signed [folb_pkg::SampleBits-1:0] filtered_due_q[$];
  int n_items      = 0;
  int n_sent       = 0;
  int n_accepted   = 0;
  int n_errors     = 0;
  int hold_left    = 0;
  int next_hold_at = 300;
  int send_idle_pct;
  int recv_idle_pct;

  first_order_lowpass_bank dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .channel_i   (channel_i),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .filtered_o  (filtered_o)
  );

  // clock and reset
  always #4 clk_i = ~clk_i;

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #2000000;
    $display("[first_order_lowpass_bank] ERROR");
    $finish;
  end

  // one filter step: update the history and return the rounded, saturated output
  function automatic logic signed [folb_pkg::SampleBits-1:0] lowpass_predict(
    logic [folb_pkg::OpW-1:0] op, logic [folb_pkg::ChanW-1:0] ch,
    logic signed [folb_pkg::SampleBits-1:0] smp);
    longint half, pole, gain, xs, yp, hi, lo, py, y, o;
    half = longint'(1) <<< (folb_pkg::FracBits - 1);
    // unused cutoff or channel: no history touched, zero out
    if (op >= folb_pkg::NumCutoffs || ch >= folb_pkg::DefChannels) return '0;
    pole = (LpPoleQ24[op] + (longint'(1) <<< (CoefDrop - 1))) >>> CoefDrop;
    gain = (LpInvGainQ24[op] + (longint'(1) <<< (CoefDrop - 1))) >>> CoefDrop;
    xs = longint'(smp) * gain;
    yp = output_hist[op][ch];
    hi = yp >>> folb_pkg::FracBits;
    lo = yp - (hi <<< folb_pkg::FracBits);
    py = pole * hi + ((pole * lo + half) >>> folb_pkg::FracBits);
    y  = scaled_in_hist[op][ch] + xs + py;
    scaled_in_hist[op][ch] = xs;
    output_hist[op][ch]    = y;
    o = (y + half) >>> folb_pkg::FracBits;
    if (o > SampleMax) o = SampleMax;
    if (o < SampleMin) o = SampleMin;
    return folb_pkg::SampleBits'(o);
  endfunction

  task automatic report_mismatch(input string msg);
    n_errors++;
    $display("%0t ns mismatch: %s", $time, msg);
  endtask

  task automatic add_item(input int op, input int ch, input int smp);
    lp_item_t it;
    it.op  = folb_pkg::OpW'(op);
    it.ch  = folb_pkg::ChanW'(ch);
    it.smp = folb_pkg::SampleBits'(smp);
    sample_q.push_back(it);
  endtask

  // idling profile: sender light / receiver heavy, then swapped, then none
  always_comb begin
    if (n_sent * 3 < n_items) begin
      send_idle_pct = 17;
      recv_idle_pct = 59;
    end else if (n_sent * 3 < n_items * 2) begin
      send_idle_pct = 59;
      recv_idle_pct = 17;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  end

  // input driver: predict on acceptance, then offer the next pending transaction
  always @(posedge clk_i or negedge rst_ni) begin : drive_p
    logic     took;
    lp_item_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      took = in_valid_i && in_ready_o;
      if (took) begin
        filtered_due_q.push_back(lowpass_predict(operation_i, channel_i, sample_i));
        n_accepted <= n_accepted + 1;
      end
      if (!in_valid_i || took) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = sample_q.pop_front();
          in_valid_i  <= 1'b1;
          operation_i <= nxt.op;
          channel_i   <= nxt.ch;
          sample_i    <= nxt.smp;
          n_sent      <= n_sent + 1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off so the result queue fills and input stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (n_accepted >= next_hold_at) begin
      hold_left    <= HoldLen;
      next_hold_at <= next_hold_at + 700;
    end
  end

  // output ready
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin : watch_p
    logic signed [folb_pkg::SampleBits-1:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (filtered_due_q.size() == 0) begin
        report_mismatch($sformatf("result %0d with none outstanding", filtered_o));
      end else begin
        want = filtered_due_q.pop_front();
        if (filtered_o !== want)
          report_mismatch($sformatf("filtered got %0d want %0d", filtered_o, want));
      end
    end
  end

  // stimulus and end of run
  initial begin
    int op, ch, len, style, lvl, smp;
    foreach (scaled_in_hist[i, j]) begin
      scaled_in_hist[i][j] = 0;
      output_hist[i][j]    = 0;
    end

    // every cutoff select, used and unused, at full scale
    for (int k = 0; k < NumOps; k++) add_item(k, k, SmpMaxInt);
    // long negative step on the fastest filter, top channel
    for (int k = 0; k < 6; k++) add_item(int'(folb_pkg::Cut8Hz), NumChans - 1, SmpMinInt);
    // positive step on the slowest filter
    for (int k = 0; k < 3; k++) begin
      add_item(int'(folb_pkg::CutHalfHz), NumChans - 1, SmpMaxInt);
    end
    // small values around zero
    add_item(int'(folb_pkg::Cut4Hz), 0, 0);
    add_item(int'(folb_pkg::Cut4Hz), 0, -1);
    add_item(int'(folb_pkg::Cut4Hz), 0, 1);
    // unused selects, on the last channel and on channel 0
    add_item(NumOps - 1, NumChans - 1, SmpMinInt);
    add_item(folb_pkg::NumCutoffs, 0, -1);

    // random bursts on one filter, with some unused-select noise
    while (sample_q.size() < 1300) begin
      if ($urandom_range(99) < 10) begin
        add_item($urandom_range(folb_pkg::NumCutoffs, NumOps - 1),
                 $urandom_range(NumChans - 1), $urandom_range(65535));
      end else begin
        op    = $urandom_range(folb_pkg::NumCutoffs - 1);
        ch    = $urandom_range(NumChans - 1);
        len   = $urandom_range(1, 12);
        style = $urandom_range(3);
        lvl   = $urandom_range(1) ? SmpMaxInt : SmpMinInt;
        if (style == 2) lvl = int'($signed(16'($urandom_range(65535))));
        for (int k = 0; k < len; k++) begin
          unique case (style)
            0:       smp = $urandom_range(65535);
            1:       smp = lvl;
            2:       smp = lvl + $urandom_range(64) - 32;
            default: smp = (k % 2 == 0) ? SmpMaxInt : SmpMinInt;
          endcase
          add_item(op, ch, smp);
        end
      end
    end
    n_items = sample_q.size();

    // drain
    @(posedge clk_i);
    while (sample_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (filtered_due_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    if (n_errors == 0) begin
      $display("[first_order_lowpass_bank] OK");
    end else begin
      $display("[first_order_lowpass_bank] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/folb_pkg.sv
src/first_order_lowpass_bank.sv
tb/sv/first_order_lowpass_bank_tb.sv
